// ===== sv/smcp_pkg.sv =====
// Shared types and constants for the serial motion command parser.
// No dependencies; imported by serial_motion_command_parser.
package smcp_pkg;

  // Configuration register indexes (byte address is 4 * index)
  localparam int unsigned CfgAddrW = 5;
  localparam logic [2:0] REG_SEND_ENABLED   = 3'd0;
  localparam logic [2:0] REG_POLARITY_LEFT  = 3'd1;
  localparam logic [2:0] REG_FWD_REDUCE     = 3'd2;
  localparam logic [2:0] REG_SUFFIX_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_PREFIX_TIMEOUT = 3'd4;

  localparam logic [15:0] SUFFIX_TIMEOUT_RST = 16'd50;
  localparam logic [15:0] PREFIX_TIMEOUT_RST = 16'd200;

  localparam int unsigned GoalW = 20;
  localparam logic [GoalW-1:0] GOAL_CAP = GoalW'(1000000);
  localparam logic [3:0] MAX_DIGITS = 4'd11;

  // Result queue
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);

  // ASCII codes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;

  // Deferred command codes
  localparam logic [2:0] CODE_FWD   = 3'd0;
  localparam logic [2:0] CODE_PARK  = 3'd1;
  localparam logic [2:0] CODE_LEFT  = 3'd2;
  localparam logic [2:0] CODE_RIGHT = 3'd3;
  localparam logic [2:0] CODE_BACK  = 3'd4;

  // Move directions
  localparam logic [1:0] DIR_FWD   = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_BACK  = 2'd3;

  typedef enum logic [3:0] {
    ACT_NONE     = 4'd0,
    ACT_RESET    = 4'd1,
    ACT_MOVE     = 4'd2,
    ACT_SPIN_CW  = 4'd3,
    ACT_SPIN_CCW = 4'd4,
    ACT_CANCEL   = 4'd5,
    ACT_PARK     = 4'd6,
    ACT_FINAL    = 4'd7,
    ACT_REPLY0   = 4'd8,
    ACT_REPORT   = 4'd9
  } action_e;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_CR   = 2'd1,
    ST_DONE = 2'd2
  } status_e;

  // Action part of a result, action in the low bits
  typedef struct packed {
    logic             lat;
    logic             sfx;
    logic [GoalW-1:0] goal;
    logic [1:0]       dir;
    action_e          action;
  } act_t;

  // Full result word, laid out as the output tdata
  typedef struct packed {
    logic    ignore;
    logic    wait_pfx;
    status_e status;
    act_t    act;
  } res_t;

  // Parser state
  typedef struct packed {
    logic             skip;
    logic             await2;
    logic             asel;
    logic             spend;
    logic             sbad;
    logic             plus;
    logic [2:0]       code;
    logic [3:0]       dc;
    logic [GoalW-1:0] gacc;
    logic [31:0]      last_act;
    logic             rst_pend;
    status_e          status;
  } st_t;

  localparam act_t ACT_ZERO = '{lat: 1'b0, sfx: 1'b0, goal: '0, dir: DIR_FWD,
                                action: ACT_NONE};

endpackage

// ===== sv/serial_motion_command_parser.sv =====
// Serial motion command parser: input register, single-pass decode, result queue.
// Depends on smcp_pkg.
//
// Usage:
//   Slave stream: one transfer per item. tuser = cmd (0 received byte, 1 poll
//   tick); tdata = rx_byte in [7:0], now_ms in [39:8].
//   Master stream: one transfer per result; tlast marks the final result of
//   an item. A byte gives one result, a poll one or two (reset first, then a
//   timed-out suffix command). tdata lists action, direction, goal, flags and
//   the parser status after the item.
//   APB port: five registers at byte addresses 0, 4, 8, 12, 16; pready is
//   always high; write only while the block is idle.
// Timing:
//   An input transfer passes through the input register and is decoded
//   into a four-entry result queue in a single pass. One item is taken
//   every cycle while the queue has room: input ready drops only while the
//   queue holds more than two results, so items that give two results each
//   are limited by the one-result-per-cycle output.
// Reset: clears parser state, queue and registers to their defaults.
// Stall: results wait in the queue; input is held off while it holds more than two results.
module serial_motion_command_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Received bytes and poll ticks
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [39:0]                  s_axis_tdata_i,  // rx_byte, now_ms
  input  logic                         s_axis_tuser_i,  // cmd
  // Results
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // action, motion_dir, goal, has_suffix, lateral_report, rx_status,
  // prefix_wait, ignore_flag
  output logic [31:0]                  m_axis_tdata_o,
  output logic                         m_axis_tlast_o,
  // Configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [smcp_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import smcp_pkg::*;

  // Configuration registers
  logic             send_en_q;
  logic             pol_left_q;
  logic [GoalW-1:0] fwd_reduce_q;
  logic [15:0]      sfx_to_q;
  logic [15:0]      pfx_to_q;
  logic             cfg_wr;
  logic [2:0]       cfg_idx;

  // Input register
  logic             in_valid_q;
  logic             in_cmd_q;
  logic [7:0]       in_ch_q;
  logic [31:0]      in_now_q;
  logic             s_accept;
  logic             process;

  // Parser
  st_t              st_q;
  st_t              st_d;
  logic [31:0]      elapsed;
  logic             pfx_to;
  logic             sfx_to;
  logic             is_eol;
  logic             is_digit;
  logic [23:0]      gmul;
  act_t             push_a;
  act_t             push_b;
  logic             a_v;
  logic             b_v;

  // Deferred command execution, from current state
  act_t             ex_act;
  logic             ex_v;
  status_e          ex_status;
  logic             ex_bad;
  logic [GoalW-1:0] ex_g;
  logic [GoalW-1:0] ex_gred;
  logic             ex_lat;

  // Result queue
  res_t             fifo_q [FifoDepth];
  logic             fifo_last_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q;
  logic [FifoPtrW-1:0] rd_ptr_q;
  logic [FifoPtrW:0]   cnt_q;
  logic             pop;
  res_t             res0;
  res_t             res1;
  logic             two;

  function automatic st_t clr_deferred(st_t s);
    st_t r;
    r       = s;
    r.spend = 1'b0;
    r.sbad  = 1'b0;
    r.code  = CODE_FWD;
    r.plus  = 1'b0;
    r.dc    = '0;
    r.gacc  = '0;
    return r;
  endfunction

  function automatic st_t clr_parser(st_t s);
    st_t r;
    r        = clr_deferred(s);
    r.skip   = 1'b0;
    r.await2 = 1'b0;
    r.asel   = 1'b0;
    r.status = ST_NONE;
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CfgAddrW-1:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_en_q    <= 1'b1;
      pol_left_q   <= 1'b0;
      fwd_reduce_q <= '0;
      sfx_to_q     <= SUFFIX_TIMEOUT_RST;
      pfx_to_q     <= PREFIX_TIMEOUT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SEND_ENABLED:   send_en_q    <= pwdata[0];
        REG_POLARITY_LEFT:  pol_left_q   <= pwdata[0];
        REG_FWD_REDUCE:     fwd_reduce_q <= pwdata[GoalW-1:0];
        REG_SUFFIX_TIMEOUT: sfx_to_q     <= pwdata[15:0];
        REG_PREFIX_TIMEOUT: pfx_to_q     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SEND_ENABLED:   prdata = {31'd0, send_en_q};
      REG_POLARITY_LEFT:  prdata = {31'd0, pol_left_q};
      REG_FWD_REDUCE:     prdata = {{(32-GoalW){1'b0}}, fwd_reduce_q};
      REG_SUFFIX_TIMEOUT: prdata = {16'd0, sfx_to_q};
      REG_PREFIX_TIMEOUT: prdata = {16'd0, pfx_to_q};
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- input
  assign process         = in_valid_q & (cnt_q <= (FifoPtrW+1)'(FifoDepth - 2));
  assign s_axis_tready_o = ~in_valid_q | process;
  assign s_accept        = s_axis_tvalid_i & s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_cmd_q <= s_axis_tuser_i;
      in_ch_q  <= s_axis_tdata_i[7:0];
      in_now_q <= s_axis_tdata_i[39:8];
    end
  end

  // ---------------------------------------------------------------- execute
  always_comb begin
    ex_bad  = st_q.sbad | (st_q.plus & (st_q.dc == '0));
    ex_g    = st_q.plus ? st_q.gacc : '0;
    ex_gred = (ex_g <= fwd_reduce_q) ? GoalW'(1) : ex_g - fwd_reduce_q;
    ex_lat  = ~pol_left_q & st_q.plus &
              ((st_q.code == CODE_LEFT) | (st_q.code == CODE_RIGHT));
    ex_act    = ACT_ZERO;
    ex_v      = 1'b0;
    ex_status = ST_DONE;
    if (ex_bad) begin
      ex_status = ST_NONE;
    end else begin
      case (st_q.code)
        CODE_PARK: begin
          if (st_q.plus && st_q.dc == 4'd1 && ex_g <= GoalW'(1)) begin
            ex_act.action = ACT_PARK;
            ex_act.goal   = ex_g;
            ex_v          = 1'b1;
          end else begin
            ex_status = ST_NONE;
          end
        end
        CODE_FWD: begin
          ex_act.action = ACT_MOVE;
          ex_act.dir    = DIR_FWD;
          ex_act.goal   = (pol_left_q && st_q.plus) ? ex_gred : ex_g;
          ex_act.sfx    = st_q.plus;
          ex_v          = send_en_q;
        end
        CODE_LEFT: begin
          if (st_q.plus && ex_g == '0) begin
            ex_act.action = ACT_CANCEL;
          end else begin
            ex_act.action = ACT_MOVE;
            ex_act.dir    = DIR_LEFT;
            ex_act.goal   = ex_g;
            ex_act.sfx    = st_q.plus;
          end
          ex_act.lat = ex_lat;
          ex_v       = send_en_q;
        end
        CODE_RIGHT: begin
          ex_act.action = ACT_MOVE;
          ex_act.dir    = DIR_RIGHT;
          ex_act.goal   = ex_g;
          ex_act.sfx    = st_q.plus;
          ex_act.lat    = ex_lat;
          ex_v          = send_en_q;
        end
        CODE_BACK: begin
          ex_act.action = ACT_MOVE;
          ex_act.dir    = DIR_BACK;
          ex_act.goal   = ex_g;
          ex_act.sfx    = st_q.plus;
          ex_v          = send_en_q;
        end
        default: ex_status = ST_NONE;
      endcase
    end
    if (!send_en_q && ex_act.action != ACT_PARK) begin
      ex_act = ACT_ZERO;
    end
  end

  // ---------------------------------------------------------------- parser
  assign elapsed  = in_now_q - st_q.last_act;
  assign pfx_to   = (st_q.skip | st_q.await2 | st_q.asel) & (elapsed > {16'd0, pfx_to_q});
  assign sfx_to   = elapsed > {16'd0, sfx_to_q};
  assign is_eol   = (in_ch_q == CH_CR) | (in_ch_q == CH_LF);
  assign is_digit = (in_ch_q >= CH_0) & (in_ch_q <= CH_9);
  assign gmul     = {1'b0, st_q.gacc, 3'b000} + {3'b000, st_q.gacc, 1'b0} +
                    24'(in_ch_q - CH_0);

  always_comb begin
    st_d   = st_q;
    push_a = ACT_ZERO;
    push_b = ACT_ZERO;
    a_v    = 1'b0;
    b_v    = 1'b0;
    if (!in_cmd_q) begin
      if (st_q.spend) begin
        st_d.last_act = in_now_q;
        if (is_eol) begin
          st_d        = clr_deferred(st_d);
          st_d.status = ex_status;
          push_b      = ex_act;
          b_v         = ex_v;
        end else if (!st_q.sbad) begin
          if (in_ch_q == CH_PLUS && !st_q.plus && st_q.dc == '0) begin
            st_d.plus = 1'b1;
          end else if (st_q.plus && is_digit) begin
            if (st_q.dc < MAX_DIGITS) begin
              st_d.dc   = st_q.dc + 4'd1;
              st_d.gacc = (gmul > 24'(GOAL_CAP)) ? GOAL_CAP : gmul[GoalW-1:0];
            end
          end else begin
            st_d.sbad = 1'b1;
          end
        end
      end else begin
        if (pfx_to) begin
          st_d = clr_parser(st_d);
        end
        st_d.last_act = in_now_q;
        if (st_d.skip) begin
          if (is_eol) begin
            st_d = clr_parser(st_d);
          end
        end else if (st_d.asel) begin
          st_d.asel = 1'b0;
          if (in_ch_q >= CH_0 && in_ch_q <= CH_2) begin
            if (send_en_q) begin
              if ((in_ch_q == CH_0) && !pol_left_q) begin
                push_b.action = ACT_REPLY0;
                b_v           = 1'b1;
              end
              if (((in_ch_q == CH_1) && pol_left_q) ||
                  ((in_ch_q == CH_2) && !pol_left_q)) begin
                push_b.action = ACT_REPORT;
                b_v           = 1'b1;
              end
            end
            st_d.status = ST_DONE;
          end else begin
            st_d.status = ST_NONE;
          end
        end else if (st_d.await2) begin
          st_d.await2 = 1'b0;
          case (in_ch_q)
            CH_1, CH_4, CH_5, CH_6, CH_8: begin
              st_d       = clr_deferred(st_d);
              st_d.spend = 1'b1;
              case (in_ch_q)
                CH_1:    st_d.code = CODE_FWD;
                CH_4:    st_d.code = CODE_PARK;
                CH_5:    st_d.code = CODE_LEFT;
                CH_6:    st_d.code = CODE_RIGHT;
                default: st_d.code = CODE_BACK;
              endcase
            end
            CH_7: begin
              st_d.asel   = 1'b1;
              st_d.status = ST_NONE;
            end
            CH_0: begin
              st_d.rst_pend = 1'b1;
              st_d.status   = ST_DONE;
            end
            CH_2, CH_3, CH_9: begin
              case (in_ch_q)
                CH_2:    push_b.action = ACT_SPIN_CW;
                CH_3:    push_b.action = ACT_SPIN_CCW;
                default: push_b.action = ACT_FINAL;
              endcase
              b_v         = send_en_q;
              st_d.status = ST_DONE;
            end
            default: st_d.status = (in_ch_q == CH_CR) ? ST_CR : ST_NONE;
          endcase
        end else begin
          if (in_ch_q == CH_1) begin
            st_d.await2 = 1'b1;
            st_d.status = ST_NONE;
          end else if (in_ch_q == CH_2 || in_ch_q == CH_3) begin
            st_d.skip   = 1'b1;
            st_d.status = ST_NONE;
          end else begin
            st_d.status = (in_ch_q == CH_CR) ? ST_CR : ST_NONE;
          end
        end
      end
    end else begin
      if (st_q.rst_pend) begin
        st_d.rst_pend = 1'b0;
        push_a.action = ACT_RESET;
        a_v           = 1'b1;
      end
      if (st_q.spend && sfx_to) begin
        st_d        = clr_deferred(st_d);
        st_d.status = ex_status;
        push_b      = ex_act;
        b_v         = ex_v;
      end
      if (pfx_to) begin
        st_d = clr_parser(st_d);
      end
    end
    if (!b_v) begin
      push_b = ACT_ZERO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (process) begin
      st_q <= st_d;
    end
  end

  // ---------------------------------------------------------------- results
  assign two             = a_v & b_v;
  assign res0.ignore     = st_d.skip;
  assign res0.wait_pfx   = st_d.await2 | st_d.asel;
  assign res0.status     = st_d.status;
  assign res0.act        = a_v ? push_a : push_b;
  assign res1.ignore     = st_d.skip;
  assign res1.wait_pfx   = st_d.await2 | st_d.asel;
  assign res1.status     = st_d.status;
  assign res1.act        = push_b;

  assign pop             = m_axis_tvalid_o & m_axis_tready_i;
  assign m_axis_tvalid_o = cnt_q != '0;
  assign m_axis_tdata_o  = fifo_q[rd_ptr_q];
  assign m_axis_tlast_o  = fifo_last_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (process) begin
      fifo_q[wr_ptr_q]      <= res0;
      fifo_last_q[wr_ptr_q] <= ~two;
      if (two) begin
        fifo_q[wr_ptr_q + FifoPtrW'(1)]      <= res1;
        fifo_last_q[wr_ptr_q + FifoPtrW'(1)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (process) begin
        wr_ptr_q <= wr_ptr_q + (two ? FifoPtrW'(2) : FifoPtrW'(1));
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      cnt_q <= cnt_q + (process ? (two ? (FifoPtrW+1)'(2) : (FifoPtrW+1)'(1))
                                : (FifoPtrW+1)'(0))
                     - (pop ? (FifoPtrW+1)'(1) : (FifoPtrW+1)'(0));
    end
  end

endmodule
